### design/nebpc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// nebpc_pkg
// Shared widths, codes, control structs and rounding helpers for the NLMS
// error-bounded predictive coder.
// ----------------------------------------------------------------------------
package nebpc_pkg;

  localparam int SMP_W  = 32;   // Q16.16 sample width
  localparam int W_W    = 32;   // Q4.28 weight width
  localparam int CODE_W = 16;   // quantization code width
  localparam int EB_W   = 31;   // error bound register width
  localparam int ACC_W  = 48;   // prediction accumulators
  localparam int DOT_W  = 56;   // tap energy accumulator
  localparam int DIV_W  = 64;   // divider operand width
  localparam int DIV_QB = 40;   // quotient bits produced by the divider
  localparam int CFG_AW = 2;    // config register index width

  // Configuration register indexes.
  localparam logic [CFG_AW-1:0] CFG_ERROR_BOUND = 2'd0;
  localparam logic [CFG_AW-1:0] CFG_ZIGZAG      = 2'd1;
  localparam logic [CFG_AW-1:0] CFG_DIRECTION   = 2'd2;

  localparam logic signed [CODE_W-1:0] IDX_MIN = 16'sh8000;  // escape index
  localparam logic signed [CODE_W-1:0] IDX_MAX = 16'sh7fff;

  typedef struct packed {
    logic load;    // capture tap operands from the history line
    logic shift;   // move every cell's contents one place down the chain
  } cell_ctl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

  // Arithmetic right shift with rounding to nearest, ties away from zero.
  function automatic logic signed [63:0] rnd_shr(input logic signed [63:0] v,
                                                 input int unsigned sh);
    logic [63:0] mag;
    logic [63:0] q;
    mag = v[63] ? 64'(-v) : 64'(v);
    q   = (mag + (64'd1 << (sh - 1))) >> sh;
    return v[63] ? -$signed(q) : $signed(q);
  endfunction

  function automatic logic signed [SMP_W-1:0] sat32(input logic signed [63:0] v);
    if (v > 64'sh000000007fffffff) begin
      return 32'sh7fffffff;
    end else if (v < -64'sh0000000080000000) begin
      return 32'sh80000000;
    end
    return v[SMP_W-1:0];
  endfunction

endpackage
`default_nettype wire

### design/nebpc_in_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// nebpc_in_if
// Input channel: one sample beat with its code, valid/ready handshake.
// ----------------------------------------------------------------------------
interface nebpc_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] sample;
  logic [15:0]        code_in;

  modport source (output valid, output sample, output code_in, input ready);
  modport sink   (input valid, input sample, input code_in, output ready);
endinterface
`default_nettype wire

### design/nebpc_out_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// nebpc_out_if
// Result channel: code, escape flag and reconstruction, valid/ready handshake.
// ----------------------------------------------------------------------------
interface nebpc_out_if;
  logic               valid;
  logic               ready;
  logic [15:0]        code_out;
  logic               is_outlier;
  logic signed [31:0] recon;

  modport source (output valid, output code_out, output is_outlier, output recon,
                  input ready);
  modport sink   (input valid, input code_out, input is_outlier, input recon,
                  output ready);
endinterface
`default_nettype wire

### design/nlms_error_bounded_predictive_coder.sv
// ----------------------------------------------------------------------------
// nlms_error_bounded_predictive_coder
// Error-bounded predictive coder with an NLMS predictor over reconstructed
// samples, compress or decompress direction, optional zigzag codes.
// Beats are handled one at a time: a new beat is taken only in the idle
//   state, once the previous result has gone to the output register, so
//   with a full history the two TAPS-long passes around the cell chain and
//   the radix-2 divider set the beat rate.
// Reset (synchronous, rst_n low): weights and history fill cleared, config
//   back to error bound 1.0, no zigzag, compress.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module nlms_error_bounded_predictive_coder
  import nebpc_pkg::*;
#(
  parameter int TAPS   = 32,
  parameter int STRIDE = 1
)
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  nebpc_in_if.sink               in_bus,
  nebpc_out_if.source            out_bus,
  input  wire logic              cfg_we,
  input  wire logic [CFG_AW-1:0] cfg_index,
  input  wire logic [EB_W-1:0]   cfg_data
);

  // The history is a shift line: entry HLEN-1 is the newest sample, and once
  // the line is full entry i is the i-th oldest of the window.
  localparam int HLEN = (TAPS + 1) * STRIDE;
  localparam int FW   = $clog2(HLEN + 1);
  localparam int CW   = $clog2(TAPS + 1);

  typedef enum logic [13:0] {
    S_IDLE  = 14'b00000000000001,
    S_LOAD  = 14'b00000000000010,
    S_PA    = 14'b00000000000100,
    S_PA_D  = 14'b00000000001000,
    S_ERR   = 14'b00000000010000,
    S_GDIV  = 14'b00000000100000,
    S_PB    = 14'b00000001000000,
    S_PB_D1 = 14'b00000010000000,
    S_PB_D2 = 14'b00000100000000,
    S_PRED  = 14'b00001000000000,
    S_QSET  = 14'b00010000000000,
    S_QDIV  = 14'b00100000000000,
    S_QMUL  = 14'b01000000000000,
    S_QFIN  = 14'b10000000000000
  } state_t;

  state_t st_r, st_nxt;

  // Configuration registers.
  logic [EB_W-1:0] eb_r;
  logic            zz_r;
  logic            dir_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      eb_r  <= EB_W'(65536);
      zz_r  <= 1'b0;
      dir_r <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_ERROR_BOUND: eb_r  <= cfg_data;
        CFG_ZIGZAG:      zz_r  <= cfg_data[0];
        CFG_DIRECTION:   dir_r <= cfg_data[0];
        default:         ;
      endcase
    end
  end

  // Input capture.
  logic                    in_acc;
  logic signed [SMP_W-1:0] smp_r;
  logic [CODE_W-1:0]       cin_r;

  assign in_bus.ready = (st_r == S_IDLE);
  assign in_acc       = in_bus.valid && in_bus.ready;

  always_ff @(posedge clk) begin
    if (in_acc) begin
      smp_r <= in_bus.sample;
      cin_r <= in_bus.code_in;
    end
  end

  // History line and fill count.
  logic signed [SMP_W-1:0] hist_r [HLEN];
  logic [FW-1:0]           fill_r;
  logic                    push;
  logic signed [SMP_W-1:0] recon_v;
  logic                    hist_full;

  assign hist_full = (fill_r == FW'(HLEN));

  always_ff @(posedge clk) begin
    if (push) begin
      for (int i = 0; i < HLEN - 1; i++) begin
        hist_r[i] <= hist_r[i+1];
      end
      hist_r[HLEN-1] <= recon_v;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= '0;
    end else if (push && !hist_full) begin
      fill_r <= fill_r + 1'b1;
    end
  end

  // Cell chain. Cell 0 feeds the shared arithmetic; the last cell takes what
  // leaves cell 0, with the weight updated during the second pass, so after
  // TAPS shifts every weight is back in its own cell.
  cell_ctl_t               cell_ctl;
  logic signed [W_W-1:0]   w_o [TAPS];
  logic signed [SMP_W-1:0] h_o [TAPS];
  logic signed [SMP_W-1:0] t_o [TAPS];
  logic signed [W_W-1:0]   w_i [TAPS];
  logic signed [SMP_W-1:0] h_i [TAPS];
  logic signed [SMP_W-1:0] t_i [TAPS];
  logic signed [W_W-1:0]   wn;
  logic signed [63:0]      gx;
  logic signed [W_W-1:0]   g_r;

  assign cell_ctl.load  = (st_r == S_LOAD);
  assign cell_ctl.shift = (st_r == S_PA) || (st_r == S_PB);

  // Weight update: w += round(g * x / 16), saturated.
  always_comb begin
    gx = g_r * h_o[0];
    wn = sat32(64'(w_o[0]) + rnd_shr(gx, 4));
  end

  always_comb begin
    for (int i = 0; i < TAPS - 1; i++) begin
      w_i[i] = w_o[i+1];
      h_i[i] = h_o[i+1];
      t_i[i] = t_o[i+1];
    end
    w_i[TAPS-1] = (st_r == S_PB) ? wn : w_o[0];
    h_i[TAPS-1] = h_o[0];
    t_i[TAPS-1] = t_o[0];
  end

  for (genvar gi = 0; gi < TAPS; gi++) begin : g_cell
    nebpc_cell u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .ctl   (cell_ctl),
      .hd_ld (hist_r[gi*STRIDE]),
      .tl_ld (hist_r[gi*STRIDE+1]),
      .w_in  (w_i[gi]),
      .h_in  (h_i[gi]),
      .t_in  (t_i[gi]),
      .w_out (w_o[gi]),
      .h_out (h_o[gi]),
      .t_out (t_o[gi])
    );
  end

  logic [CW-1:0] cnt_r;
  logic          cnt_last;

  assign cnt_last = (cnt_r == CW'(TAPS - 1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (st_r == S_LOAD || st_r == S_GDIV) begin
      cnt_r <= '0;
    end else if (cell_ctl.shift) begin
      cnt_r <= cnt_last ? '0 : cnt_r + 1'b1;
    end
  end

  // First pass: y = sum round(w*head / 2^28), dot = sum round(head^2 / 2^16).
  logic signed [63:0]      pwx_r;
  logic signed [63:0]      pxx_r;
  logic                    ma_v_r;
  logic signed [ACC_W-1:0] acc_y_r;
  logic [DOT_W-1:0]        dot_r;

  always_ff @(posedge clk) begin
    pwx_r <= w_o[0] * h_o[0];
    pxx_r <= h_o[0] * h_o[0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ma_v_r <= 1'b0;
    end else begin
      ma_v_r <= (st_r == S_PA);
    end
  end

  always_ff @(posedge clk) begin
    if (st_r == S_LOAD) begin
      acc_y_r <= '0;
      dot_r   <= '0;
    end else if (ma_v_r) begin
      acc_y_r <= acc_y_r + ACC_W'(rnd_shr(pwx_r, 28));
      dot_r   <= dot_r + DOT_W'((64'(pxx_r) + 64'd32768) >> 16);
    end
  end

  // Step size: g = round(e * 2^15 / (2^16 + dot)).
  logic signed [SMP_W-1:0] e_v;
  logic [46:0]             emag;
  logic [DOT_W:0]          den_v;

  always_comb begin
    e_v   = sat32(64'(hist_r[HLEN-1]) - 64'(acc_y_r));
    emag  = {(e_v[SMP_W-1] ? 32'(-e_v) : 32'(e_v)), 15'd0};
    den_v = (DOT_W+1)'(dot_r) + (DOT_W+1)'(65536);
  end

  // Second pass: update weights, then p = sum round(w_new*tail / 2^28).
  logic signed [W_W-1:0]   wn_r;
  logic signed [SMP_W-1:0] tl_r;
  logic                    b1_v_r;
  logic signed [63:0]      pwt_r;
  logic                    b2_v_r;
  logic signed [ACC_W-1:0] acc_p_r;

  always_ff @(posedge clk) begin
    wn_r  <= wn;
    tl_r  <= t_o[0];
    pwt_r <= wn_r * tl_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b1_v_r <= 1'b0;
      b2_v_r <= 1'b0;
    end else begin
      b1_v_r <= (st_r == S_PB);
      b2_v_r <= b1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (st_r == S_GDIV) begin
      acc_p_r <= '0;
    end else if (b2_v_r) begin
      acc_p_r <= acc_p_r + ACC_W'(rnd_shr(pwt_r, 28));
    end
  end

  // Shared divider: the step size first, then the compress bin index.
  logic              div_start;
  logic [DIV_W-1:0]  div_num;
  logic [DIV_W-1:0]  div_den;
  logic [DIV_QB-1:0] div_quo;
  div_stat_t         div_stat;
  logic              neg_r;

  logic signed [SMP_W-1:0] pred_r;
  logic signed [SMP_W:0]   diff_v;
  logic [SMP_W:0]          dmag;
  logic                    eb_zero;

  assign eb_zero = (eb_r == '0);

  always_comb begin
    diff_v = (SMP_W+1)'(smp_r) - (SMP_W+1)'(pred_r);
    dmag   = diff_v[SMP_W] ? (SMP_W+1)'(-diff_v) : (SMP_W+1)'(diff_v);
  end

  always_comb begin
    div_start = 1'b0;
    div_num   = DIV_W'({emag, 1'b0}) + DIV_W'(den_v);
    div_den   = DIV_W'({den_v, 1'b0});
    if (st_r == S_ERR) begin
      div_start = 1'b1;
    end else if (st_r == S_QSET) begin
      div_num   = DIV_W'({dmag, 1'b0}) + DIV_W'({eb_r, 1'b0});
      div_den   = DIV_W'({eb_r, 2'b00});
      div_start = !dir_r && !eb_zero;
    end
  end

  nebpc_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .quo   (div_quo),
    .stat  (div_stat)
  );

  always_ff @(posedge clk) begin
    if (st_r == S_ERR) begin
      neg_r <= e_v[SMP_W-1];
    end else if (st_r == S_QSET) begin
      neg_r <= diff_v[SMP_W];
    end
  end

  always_ff @(posedge clk) begin
    if (st_r == S_GDIV && div_stat.done) begin
      g_r <= neg_r ? -$signed(W_W'(div_quo)) : $signed(W_W'(div_quo));
    end
  end

  // Prediction.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      pred_r <= (fill_r == '0) ? '0 : hist_r[HLEN-1];
    end else if (st_r == S_PRED) begin
      pred_r <= sat32(64'(acc_p_r));
    end
  end

  // Bin index: from the divider in compress, decoded from the code in
  // decompress. A zigzag code c decodes to c/2, or to ~(c/2) when c is odd.
  logic signed [CODE_W-1:0] idx_r;
  logic signed [CODE_W-1:0] dec_idx;

  always_comb begin
    if (zz_r) begin
      dec_idx = cin_r[0] ? ~{1'b0, cin_r[CODE_W-1:1]} : {1'b0, cin_r[CODE_W-1:1]};
    end else begin
      dec_idx = cin_r;
    end
  end

  always_ff @(posedge clk) begin
    if (st_r == S_QSET) begin
      idx_r <= dir_r ? dec_idx : '0;
    end else if (st_r == S_QDIV && div_stat.done) begin
      if (neg_r) begin
        idx_r <= (div_quo >= DIV_QB'(32768)) ? IDX_MIN : -$signed(CODE_W'(div_quo));
      end else begin
        idx_r <= (div_quo >= DIV_QB'(32767)) ? IDX_MAX : $signed(CODE_W'(div_quo));
      end
    end
  end

  // Bin offset 2*error_bound*index.
  logic signed [48:0] qprod_r;

  always_ff @(posedge clk) begin
    qprod_r <= $signed({1'b0, eb_r, 1'b0}) * idx_r;
  end

  // Reconstruction, escape decision and output code.
  logic signed [50:0]       rc_v;
  logic signed [51:0]       dd_v;
  logic [51:0]              ddmag;
  logic                     fits;
  logic                     esc_v;
  logic signed [CODE_W-1:0] idx_e;
  logic [CODE_W-1:0]        code_v;

  always_comb begin
    rc_v   = 51'(pred_r) + 51'(qprod_r);
    dd_v   = 52'(smp_r) - 52'(rc_v);
    ddmag  = dd_v[51] ? 52'(-dd_v) : 52'(dd_v);
    fits   = (rc_v == 51'(sat32(64'(rc_v))));
    code_v = '0;
    if (!dir_r) begin
      esc_v   = (idx_r == IDX_MIN) || (ddmag > 52'(eb_r)) || !fits;
      recon_v = esc_v ? smp_r : rc_v[SMP_W-1:0];
      idx_e   = esc_v ? IDX_MIN : idx_r;
      if (zz_r) begin
        code_v = idx_e[CODE_W-1] ? {~idx_e[CODE_W-2:0], 1'b1} : {idx_e[CODE_W-2:0], 1'b0};
      end else begin
        code_v = idx_e;
      end
    end else begin
      esc_v   = (idx_r == IDX_MIN);
      idx_e   = idx_r;
      recon_v = esc_v ? smp_r : sat32(64'(rc_v));
    end
  end

  // Output register: the result waits here while the next beat is taken.
  logic                    out_valid_r;
  logic [CODE_W-1:0]       code_r;
  logic                    outl_r;
  logic signed [SMP_W-1:0] recon_r;

  assign push = (st_r == S_QFIN) && (!out_valid_r || out_bus.ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (push) begin
      out_valid_r <= 1'b1;
    end else if (out_bus.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      code_r  <= code_v;
      outl_r  <= esc_v;
      recon_r <= recon_v;
    end
  end

  assign out_bus.valid      = out_valid_r;
  assign out_bus.code_out   = code_r;
  assign out_bus.is_outlier = outl_r;
  assign out_bus.recon      = recon_r;

  // Sequencer.
  always_comb begin
    st_nxt = st_r;
    case (st_r)
      S_IDLE:  if (in_acc) st_nxt = hist_full ? S_LOAD : S_QSET;
      S_LOAD:  st_nxt = S_PA;
      S_PA:    if (cnt_last) st_nxt = S_PA_D;
      S_PA_D:  st_nxt = S_ERR;
      S_ERR:   st_nxt = S_GDIV;
      S_GDIV:  if (div_stat.done) st_nxt = S_PB;
      S_PB:    if (cnt_last) st_nxt = S_PB_D1;
      S_PB_D1: st_nxt = S_PB_D2;
      S_PB_D2: st_nxt = S_PRED;
      S_PRED:  st_nxt = S_QSET;
      S_QSET:  st_nxt = (!dir_r && !eb_zero) ? S_QDIV : S_QMUL;
      S_QDIV:  if (div_stat.done) st_nxt = S_QMUL;
      S_QMUL:  st_nxt = S_QFIN;
      S_QFIN:  if (push) st_nxt = S_IDLE;
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE;
    end else begin
      st_r <= st_nxt;
    end
  end

  // The fill count never passes the history length.
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= FW'(HLEN))
    else $error("history fill count overran the history length");

  // The divider is never restarted while a division is in flight.
  a_div_idle: assert property (@(posedge clk) disable iff (!rst_n)
    div_start |-> !div_stat.busy)
    else $error("divider started while busy");

  // A history push always leaves a result in the output register.
  a_push_out: assert property (@(posedge clk) disable iff (!rst_n)
    push |=> out_valid_r)
    else $error("history pushed without a result beat");

  // An accepted beat starts either the chain passes or the quantizer.
  a_acc_path: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> (st_r == S_LOAD || st_r == S_QSET))
    else $error("accepted beat did not start processing");

endmodule
`default_nettype wire

### design/nebpc_cell.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// nebpc_cell
// One predictor tap: holds its weight and its head and tail operands, and
// passes all three to its neighbor while the chain circulates.
// ----------------------------------------------------------------------------
module nebpc_cell
  import nebpc_pkg::*;
(
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire cell_ctl_t               ctl,
  input  wire logic signed [SMP_W-1:0] hd_ld,
  input  wire logic signed [SMP_W-1:0] tl_ld,
  input  wire logic signed [W_W-1:0]   w_in,
  input  wire logic signed [SMP_W-1:0] h_in,
  input  wire logic signed [SMP_W-1:0] t_in,
  output logic signed [W_W-1:0]        w_out,
  output logic signed [SMP_W-1:0]      h_out,
  output logic signed [SMP_W-1:0]      t_out
);

  logic signed [W_W-1:0]   w_r;
  logic signed [SMP_W-1:0] h_r;
  logic signed [SMP_W-1:0] t_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      w_r <= '0;
    end else if (ctl.shift) begin
      w_r <= w_in;
    end
  end

  // Operands carry no reset; they are always loaded before use.
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      h_r <= hd_ld;
      t_r <= tl_ld;
    end else if (ctl.shift) begin
      h_r <= h_in;
      t_r <= t_in;
    end
  end

  assign w_out = w_r;
  assign h_out = h_r;
  assign t_out = t_r;

endmodule
`default_nettype wire

### design/nebpc_div.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// nebpc_div
// Radix-2 restoring divider, one quotient bit per cycle. The caller keeps
// the quotient below 2^DIV_QB.
// ----------------------------------------------------------------------------
module nebpc_div
  import nebpc_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  input  wire logic [DIV_W-1:0]  num,
  input  wire logic [DIV_W-1:0]  den,
  output logic [DIV_QB-1:0]      quo,
  output div_stat_t              stat
);

  localparam int CNT_W = $clog2(DIV_QB + 1);

  logic [DIV_W-1:0]  rem_r;
  logic [DIV_W-1:0]  den_r;
  logic [DIV_QB-1:0] sh_r;
  logic [CNT_W-1:0]  cnt_r;
  logic              busy_r;
  logic              done_r;
  logic [DIV_W-1:0]  trial;
  logic              qbit;

  assign trial = {rem_r[DIV_W-2:0], sh_r[DIV_QB-1]};
  assign qbit  = (trial >= den_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(DIV_QB);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // The shift register starts with the low numerator bits and fills with
  // quotient bits as they are decided.
  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= num >> DIV_QB;
      sh_r  <= num[DIV_QB-1:0];
      den_r <= den;
    end else if (busy_r) begin
      rem_r <= qbit ? (trial - den_r) : trial;
      sh_r  <= {sh_r[DIV_QB-2:0], qbit};
    end
  end

  assign quo       = sh_r;
  assign stat.busy = busy_r;
  assign stat.done = done_r;

endmodule
`default_nettype wire

### sim/nebpc_scoreboard.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nebpc_scoreboard
// Watches the input, result and register ports of the coder. It keeps its
// own copy of the NLMS predictor, history and registers, works out the beat
// each accepted input must produce and compares each result beat with it.
// ----------------------------------------------------------------------------
module nebpc_scoreboard
  import nebpc_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  nebpc_in_if               in_mon,
  nebpc_out_if              out_mon,
  input  logic              cfg_we,
  input  logic [CFG_AW-1:0] cfg_index,
  input  logic [EB_W-1:0]   cfg_data,
  output int                fail_count,
  output int                pending,
  output int                beats_checked,
  output int                escapes_seen
);

  localparam int NTAP = 32;
  localparam int HIST = NTAP + 1;

  typedef struct {
    logic [15:0]        code;
    logic               outlier;
    logic signed [31:0] recon;
  } coded_beat_t;

  coded_beat_t expected_q[$];

  longint     hist [HIST];
  longint     wts  [NTAP];
  int         fill;
  int         wptr;
  logic [30:0] bound;
  logic       zz;
  logic       decomp;

  function automatic longint clamp32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  // Division rounded to nearest, ties away from zero; den is positive.
  function automatic longint round_div(longint num, longint unsigned den);
    longint unsigned mag;
    longint unsigned q;
    mag = (num < 0) ? longint'(-num) : longint'(num);
    q = (mag * 2 + den) / (den * 2);
    return (num < 0) ? -longint'(q) : longint'(q);
  endfunction

  function automatic longint tap(int i);
    return hist[(wptr + HIST - fill + i) % HIST];
  endfunction

  // Next prediction; with a full history this also adapts the weights.
  function automatic longint predict_next();
    longint y;
    longint e;
    longint g;
    longint p;
    longint x;
    longint unsigned energy;
    y = 0;
    p = 0;
    energy = 0;
    if (fill == 0) return 0;
    if (fill < HIST) return tap(fill - 1);
    for (int k = 0; k < NTAP; k++) begin
      x = tap(k);
      y += round_div(wts[k] * x, 64'd1 << 28);
      energy += (longint'(x * x) + 32768) >> 16;
    end
    e = clamp32(tap(HIST - 1) - y);
    g = round_div(e * 32768, 65536 + energy);
    for (int k = 0; k < NTAP; k++) begin
      wts[k] = clamp32(wts[k] + round_div(g * tap(k), 16));
    end
    // The prediction uses the taps one place later than the update did.
    for (int k = 0; k < NTAP; k++) begin
      p += round_div(wts[k] * tap(1 + k), 64'd1 << 28);
    end
    return clamp32(p);
  endfunction

  function automatic coded_beat_t code_beat(logic signed [31:0] smp, logic [15:0] cin);
    coded_beat_t r;
    longint pred;
    longint eb;
    longint s;
    longint idx;
    longint rec;
    longint d;
    logic esc;
    s = smp;
    eb = bound;
    pred = predict_next();
    r.code = '0;
    if (!decomp) begin
      idx = (eb > 0) ? round_div(s - pred, 2 * eb) : 0;
      if (idx > 32767) idx = 32767;
      if (idx < -32768) idx = -32768;
      rec = pred + 2 * eb * idx;
      d = s - rec;
      if (d < 0) d = -d;
      esc = (idx == -32768) || (d > eb) || (rec != clamp32(rec));
      if (esc) begin
        idx = -32768;
        rec = s;
      end
      if (zz) r.code = (idx < 0) ? 16'((-idx) * 2 - 1) : 16'(idx * 2);
      else r.code = 16'(idx);
    end else begin
      if (zz) idx = cin[0] ? -((longint'(cin) + 1) >> 1) : (longint'(cin) >> 1);
      else idx = longint'($signed(cin));
      esc = (idx == -32768);
      rec = esc ? s : clamp32(pred + 2 * eb * idx);
    end
    hist[wptr] = rec;
    wptr = (wptr + 1) % HIST;
    if (fill < HIST) fill++;
    r.outlier = esc;
    r.recon = 32'(rec);
    return r;
  endfunction

  always @(posedge clk) begin
    coded_beat_t want;
    if (!rst_n) begin
      for (int k = 0; k < HIST; k++) hist[k] = 0;
      for (int k = 0; k < NTAP; k++) wts[k] = 0;
      fill = 0;
      wptr = 0;
      bound = 31'd65536;
      zz = 1'b0;
      decomp = 1'b0;
      expected_q.delete();
      fail_count = 0;
      beats_checked = 0;
      escapes_seen = 0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_ERROR_BOUND: bound = cfg_data;
          CFG_ZIGZAG:      zz = cfg_data[0];
          CFG_DIRECTION:   decomp = cfg_data[0];
          default: ;
        endcase
      end
      if (in_mon.valid && in_mon.ready) begin
        expected_q.insert(expected_q.size(), code_beat(in_mon.sample, in_mon.code_in));
      end
      if (out_mon.valid && out_mon.ready) begin
        if (expected_q.size() == 0) begin
          $error("result beat with nothing expected");
          fail_count++;
        end else begin
          want = expected_q.pop_front();
          beats_checked++;
          if (want.outlier) escapes_seen++;
          if (out_mon.code_out !== want.code) begin
            $error("code_out: expected %h, got %h", want.code, out_mon.code_out);
            fail_count++;
          end
          if (out_mon.is_outlier !== want.outlier) begin
            $error("is_outlier: expected %b, got %b", want.outlier, out_mon.is_outlier);
            fail_count++;
          end
          if (out_mon.recon !== want.recon) begin
            $error("recon: expected %h, got %h", want.recon, out_mon.recon);
            fail_count++;
          end
        end
      end
    end
    pending = expected_q.size();
  end

endmodule

### sim/tb_nlms_error_bounded_predictive_coder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_nlms_error_bounded_predictive_coder
// Drives the coder through directed extremes and random phases in both
// directions and code forms, with random idling on both channels.
// ----------------------------------------------------------------------------
module tb_nlms_error_bounded_predictive_coder;
  import nebpc_pkg::*;

  localparam int CYCLE_LIMIT = 1000000;
  // Extra idle time after the last result of a phase, as a safe margin.
  localparam int DRAIN_CYCLES = 200;
  localparam int LONG_HOLD = 400;
  localparam int NPHASE = 8;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [CFG_AW-1:0] cfg_index = '0;
  logic [EB_W-1:0] cfg_data = '0;

  nebpc_in_if  in_ch ();
  nebpc_out_if out_ch ();

  int fail_count;
  int pending;
  int beats_checked;
  int escapes_seen;
  int cycles = 0;
  int sent = 0;

  // Set by the stimulus (hold_left by the result side); read by the receiver and sender idling logic.
  logic no_idle = 1'b0;
  logic long_hold_req = 1'b0;
  int hold_left = 0;

  // Per-phase settings: bound, zigzag, direction, beat count.
  logic [30:0] ph_bound [NPHASE] = '{31'd65536, 31'd1, 31'h7fffffff, 31'd4096,
                                     31'd65536, 31'd300, 31'd1048576, 31'd65536};
  logic ph_zz  [NPHASE] = '{1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b0, 1'b1, 1'b1};
  logic ph_dir [NPHASE] = '{1'b0, 1'b0, 1'b0, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0};
  int   ph_len [NPHASE] = '{60, 40, 30, 50, 50, 60, 50, 60};

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  nlms_error_bounded_predictive_coder uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_bus    (in_ch),
    .out_bus   (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  nebpc_scoreboard scoreboard (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_mon        (in_ch),
    .out_mon       (out_ch),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .fail_count    (fail_count),
    .pending       (pending),
    .beats_checked (beats_checked),
    .escapes_seen  (escapes_seen)
  );

  // The run is cut off by a watchdog on its total length, so a coder that stops making progress ends it.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb_nlms_error_bounded_predictive_coder failed");
      $finish;
    end
  end

  // Result side: random stall bursts, plus one long hold-off on request so
  // that the coder backs up and stalls its input.
  always @(negedge clk) begin
    if (long_hold_req && hold_left == 0) begin
      long_hold_req = 1'b0;
      hold_left = LONG_HOLD;
    end
    if (hold_left > 0) begin
      out_ch.ready <= 1'b0;
      hold_left--;
    end else if (!no_idle && $urandom_range(0, 7) == 0) begin
      out_ch.ready <= 1'b0;
      hold_left = $urandom_range(1, 14);
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  initial begin
    out_ch.ready = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.sample = '0;
    in_ch.code_in = '0;
  end

  // Writes one register at the current falling edge; the caller lowers the
  // write enable once its group of writes is done.
  task automatic write_reg(logic [CFG_AW-1:0] idx, logic [EB_W-1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    @(negedge clk);
  endtask

  task automatic set_mode(logic [30:0] eb, logic zz, logic dir);
    write_reg(CFG_ERROR_BOUND, eb);
    write_reg(CFG_ZIGZAG, {30'd0, zz});
    write_reg(CFG_DIRECTION, {30'd0, dir});
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  // Offers one beat, optionally after an idle burst, and returns at the
  // falling edge after it was taken.
  task automatic offer_beat(logic signed [31:0] smp, logic [15:0] cin);
    int gap;
    if (!no_idle && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 15);
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.sample <= smp;
    in_ch.code_in <= cin;
    do @(posedge clk); while (!in_ch.ready);
    sent++;
    @(negedge clk);
  endtask

  // Between phases every expected beat must be back before registers move.
  task automatic settle();
    in_ch.valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  initial begin
    int phase_pos;
    int step;
    int amp;
    int noise;
    logic signed [31:0] smp;
    logic [15:0] cin;
    phase_pos = 0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed: field extremes in compress with the reset settings, then a
    // one-unit bound so index saturation and the escape path are taken.
    offer_beat(32'sd0, 16'h0000);
    offer_beat(32'sh7fffffff, 16'hffff);
    offer_beat(32'sh80000000, 16'h0000);
    offer_beat(32'sd1, 16'h0000);
    offer_beat(-32'sd1, 16'h0000);
    offer_beat(32'sd196608, 16'h0000);
    offer_beat(32'sd200000, 16'h0000);
    settle();
    set_mode(31'd1, 1'b1, 1'b0);
    offer_beat(32'sh7fffffff, 16'h0000);
    offer_beat(32'sh80000000, 16'h0000);
    offer_beat(32'sd5, 16'h0000);
    offer_beat(32'sd3, 16'h0000);
    settle();
    // Decompress with both code forms: zero, largest, escape and all ones.
    set_mode(31'd65536, 1'b0, 1'b1);
    offer_beat(32'sd12345, 16'h0000);
    offer_beat(32'sd0, 16'h7fff);
    offer_beat(32'sh5a5a5a5a, 16'h8000);
    offer_beat(32'sd0, 16'hffff);
    offer_beat(32'sd0, 16'h0001);
    settle();
    set_mode(31'h7fffffff, 1'b1, 1'b1);
    offer_beat(32'sd0, 16'h0000);
    offer_beat(32'sd0, 16'hfffe);
    offer_beat(32'sh80000000, 16'hffff);
    offer_beat(32'sd0, 16'h0001);
    offer_beat(32'sd0, 16'h0002);
    settle();

    // Random phases. Compress mostly follows a slow triangle wave so the
    // predictor adapts; the rest are jumps and raw random samples.
    for (int ph = 0; ph < NPHASE; ph++) begin
      if (ph == NPHASE - 1) no_idle = 1'b1;
      set_mode(ph_bound[ph], ph_zz[ph], ph_dir[ph]);
      amp = $urandom_range(1, 64) * 65536;
      step = $urandom_range(1, 8);
      for (int n = 0; n < ph_len[ph]; n++) begin
        if (ph == 0 && n == 10) long_hold_req = 1'b1;
        phase_pos = (phase_pos + step) % 64;
        noise = $urandom_range(0, 2047);
        smp = 32'((phase_pos < 32 ? phase_pos : 64 - phase_pos) * (amp / 32))
              + 32'(noise) - 32'sd1024;
        case ($urandom_range(0, 9))
          0: smp = $urandom;
          1: smp = smp + 32'($urandom_range(0, 32'h00ffffff)) - 32'sh00800000;
          default: ;
        endcase
        case ($urandom_range(0, 19))
          0: cin = ph_zz[ph] ? 16'hffff : 16'h8000;
          1, 2: cin = 16'($urandom);
          default: cin = ph_zz[ph] ? 16'($urandom_range(0, 15))
                                   : 16'($urandom_range(0, 15)) - 16'd7;
        endcase
        offer_beat(smp, cin);
      end
      settle();
    end

    $display("Sent %0d beats, checked %0d results, %0d of them escapes.",
             sent, beats_checked, escapes_seen);
    $display("Covered both directions, both code forms and bounds from 1 to the maximum.");
    if (fail_count == 0) begin
      $display("tb_nlms_error_bounded_predictive_coder passed");
    end else begin
      $display("tb_nlms_error_bounded_predictive_coder failed");
    end
    $finish;
  end

endmodule
